### design/hangul_glyph_address_gen_defines.svh
// Assertion helpers shared by the Hangul glyph address generator.
`ifndef HANGUL_GLYPH_ADDRESS_GEN_DEFINES_SVH
`define HANGUL_GLYPH_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HGAG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HGAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hgag_pkg.sv
`timescale 1ns / 1ps
package hgag_pkg;

  // Field widths.
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 5;
  localparam int INIT_ADDR_W = 13;
  localparam int MED_ADDR_W = 13;
  localparam int FIN_ADDR_W = 14;
  localparam int CP_W       = 16;
  localparam int SYL_W      = 14;
  localparam int Q28_W      = 9;
  localparam int SLOT_W     = 9;

  // Default glyph size in bytes.
  localparam int GLYPH_BYTES_DEF = 32;

  // Syllable block of the code space.
  localparam logic [CP_W-1:0] SYL_BASE = 16'hAC00;
  localparam logic [CP_W-1:0] SYL_LAST = 16'hD7A3;

  // Constant division: s / 28 == (s * 9363) >> 18 for all s below 11172,
  // and t / 21 == (t * 391) >> 13 for all t below 399.
  localparam logic [SYL_W-1:0] RECIP_28 = 14'd9363;
  localparam int RECIP_28_SH = 18;
  localparam logic [Q28_W-1:0] RECIP_21 = 9'd391;
  localparam int RECIP_21_SH = 13;

  // Glyph slot areas in font memory.
  localparam logic [SLOT_W-1:0] MEDIAL_AREA = 9'd160;
  localparam logic [SLOT_W-1:0] FINAL_AREA  = 9'd248;

  // Variant tables of the 8x4x4 composed font.
  localparam logic [2:0] INIT_VAR_TAB [0:41] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd3,
    3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7, 3'd7,
    3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5};

  localparam logic [1:0] MED_VAR_TAB [0:37] = '{
    2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1,
    2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3, 2'd3};

  localparam logic [1:0] FIN_VAR_TAB [0:20] = '{
    2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2,
    2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1};

  // Request state between the split stage and the compose stage.
  typedef struct packed {
    logic              valid;
    logic              not_syl;
    logic [Q28_W-1:0]  q28;
    logic [IDX_W-1:0]  fin;
  } split_t;

endpackage

### design/hgag_split.sv
`timescale 1ns / 1ps
module hgag_split (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [hgag_pkg::BYTE_W-1:0]   lead_byte,
  input  logic [hgag_pkg::BYTE_W-1:0]   second_byte,
  input  logic [hgag_pkg::BYTE_W-1:0]   third_byte,
  output hgag_pkg::split_t              split
);

  logic [hgag_pkg::CP_W-1:0]           cp;
  logic [hgag_pkg::CP_W-1:0]           cp_off;
  logic                                not_syl;
  logic [hgag_pkg::SYL_W-1:0]          s;
  logic [2*hgag_pkg::SYL_W-1:0]        prod;
  logic [hgag_pkg::Q28_W-1:0]          q28;
  logic [hgag_pkg::SYL_W-1:0]          rem;
  hgag_pkg::split_t                    split_next;

  // Rebuild the code point and test it against the syllable block.
  always_comb begin
    cp      = {lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
    cp_off  = cp - hgag_pkg::SYL_BASE;
    not_syl = (cp < hgag_pkg::SYL_BASE) || (cp > hgag_pkg::SYL_LAST);
    s       = not_syl ? '0 : cp_off[hgag_pkg::SYL_W-1:0];
  end

  // Divide the syllable offset by 28 with a reciprocal multiply.
  always_comb begin
    prod = s * hgag_pkg::RECIP_28;
    q28  = prod[hgag_pkg::RECIP_28_SH +: hgag_pkg::Q28_W];
    rem  = s - (hgag_pkg::SYL_W'(q28) * hgag_pkg::SYL_W'(28));
    split_next.valid   = in_valid;
    split_next.not_syl = not_syl;
    split_next.q28     = q28;
    split_next.fin     = rem[hgag_pkg::IDX_W-1:0];
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      split.valid <= 1'b0;
    end else begin
      split.valid <= split_next.valid;
    end
    split.not_syl <= split_next.not_syl;
    split.q28     <= split_next.q28;
    split.fin     <= split_next.fin;
  end

endmodule

### design/hgag_compose.sv
`timescale 1ns / 1ps
module hgag_compose #(
  parameter int GLYPH_BYTES = hgag_pkg::GLYPH_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hgag_pkg::split_t                   split,
  output logic                               done,
  output logic [hgag_pkg::IDX_W-1:0]         initial_index,
  output logic [hgag_pkg::IDX_W-1:0]         medial_index,
  output logic [hgag_pkg::IDX_W-1:0]         final_index,
  output logic [hgag_pkg::INIT_ADDR_W-1:0]   initial_glyph_addr,
  output logic [hgag_pkg::MED_ADDR_W-1:0]    medial_glyph_addr,
  output logic [hgag_pkg::FIN_ADDR_W-1:0]    final_glyph_addr,
  output logic                               not_syllable
);

  localparam int GB_W   = $clog2(GLYPH_BYTES + 1);
  localparam int PROD_W = (hgag_pkg::SLOT_W + GB_W > hgag_pkg::FIN_ADDR_W) ?
                          hgag_pkg::SLOT_W + GB_W : hgag_pkg::FIN_ADDR_W;

  logic [2*hgag_pkg::Q28_W-1:0]   ini_prod;
  logic [hgag_pkg::IDX_W-1:0]     ini;
  logic [hgag_pkg::Q28_W-1:0]     med_full;
  logic [hgag_pkg::IDX_W-1:0]     med;
  logic                           hf;
  logic [5:0]                     init_sel;
  logic [5:0]                     med_sel;
  logic [2:0]                     ci;
  logic [1:0]                     mi;
  logic [1:0]                     fi;
  logic [hgag_pkg::SLOT_W-1:0]    init_slot;
  logic [hgag_pkg::SLOT_W-1:0]    med_slot;
  logic [hgag_pkg::SLOT_W-1:0]    fin_slot;
  logic [PROD_W-1:0]              init_prod;
  logic [PROD_W-1:0]              med_prod;
  logic [PROD_W-1:0]              fin_prod;

  // Split the quotient by 28 into initial and medial indices.
  always_comb begin
    ini_prod = split.q28 * hgag_pkg::RECIP_21;
    ini      = ini_prod[hgag_pkg::RECIP_21_SH +: hgag_pkg::IDX_W];
    med_full = split.q28 - (hgag_pkg::Q28_W'(ini) * hgag_pkg::Q28_W'(21));
    med      = med_full[hgag_pkg::IDX_W-1:0];
    hf       = (split.fin != '0);
  end

  // Pick the glyph variants from the font tables.
  always_comb begin
    init_sel = hf ? (6'(med) + 6'd21) : 6'(med);
    med_sel  = hf ? (6'(ini) + 6'd19) : 6'(ini);
    ci       = hgag_pkg::INIT_VAR_TAB[init_sel];
    mi       = hgag_pkg::MED_VAR_TAB[med_sel];
    fi       = hgag_pkg::FIN_VAR_TAB[med];
  end

  // Glyph slot numbers and their byte addresses.
  always_comb begin
    init_slot = (hgag_pkg::SLOT_W'(ci) * hgag_pkg::SLOT_W'(20))
              + hgag_pkg::SLOT_W'(ini) + hgag_pkg::SLOT_W'(1);
    med_slot  = hgag_pkg::MEDIAL_AREA + (hgag_pkg::SLOT_W'(mi) * hgag_pkg::SLOT_W'(22))
              + hgag_pkg::SLOT_W'(med) + hgag_pkg::SLOT_W'(1);
    fin_slot  = hgag_pkg::FINAL_AREA + (hgag_pkg::SLOT_W'(fi) * hgag_pkg::SLOT_W'(28))
              + hgag_pkg::SLOT_W'(split.fin);
    init_prod = PROD_W'(init_slot) * PROD_W'(GLYPH_BYTES);
    med_prod  = PROD_W'(med_slot) * PROD_W'(GLYPH_BYTES);
    fin_prod  = PROD_W'(fin_slot) * PROD_W'(GLYPH_BYTES);
  end

  // Result register; a code point outside the syllable block gives zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= split.valid;
    end
    not_syllable <= split.not_syl;
    if (split.not_syl) begin
      initial_index      <= '0;
      medial_index       <= '0;
      final_index        <= '0;
      initial_glyph_addr <= '0;
      medial_glyph_addr  <= '0;
      final_glyph_addr   <= '0;
    end else begin
      initial_index      <= ini;
      medial_index       <= med;
      final_index        <= split.fin;
      initial_glyph_addr <= init_prod[hgag_pkg::INIT_ADDR_W-1:0];
      medial_glyph_addr  <= med_prod[hgag_pkg::MED_ADDR_W-1:0];
      final_glyph_addr   <= fin_prod[hgag_pkg::FIN_ADDR_W-1:0];
    end
  end

endmodule

### design/hangul_glyph_address_gen.sv
`timescale 1ns / 1ps
// Hangul glyph address generator for an 8x4x4 composed font.
// Request channel: lead_byte, second_byte and third_byte carry the three
// UTF-8 bytes of one character; a request is taken at a rising edge where
// start is high and busy is low. busy is low except during reset, so a
// request can be issued in every cycle.
// Result channel: done is high for exactly one cycle while the indices,
// the three glyph byte addresses and not_syllable are valid. The receiver
// cannot stall; it must take each result in the cycle it appears.
// A request passes through three register stages in order: input
// register, split stage (reciprocal multiply by 1/28) and compose stage
// (variant tables and address multiply), each holding one request; the
// compose stage's result register drives done and the result fields.
// Throughput is one request per cycle, set by these stages.
// A code point outside AC00..D7A3 gives not_syllable high and all other
// result fields zero.
// Reset clears every stage's valid flag; requests in flight are dropped.
`include "hangul_glyph_address_gen_defines.svh"
module hangul_glyph_address_gen #(
  parameter int GLYPH_BYTES = hgag_pkg::GLYPH_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [hgag_pkg::BYTE_W-1:0]        lead_byte,
  input  logic [hgag_pkg::BYTE_W-1:0]        second_byte,
  input  logic [hgag_pkg::BYTE_W-1:0]        third_byte,
  output logic                               done,
  output logic [hgag_pkg::IDX_W-1:0]         initial_index,
  output logic [hgag_pkg::IDX_W-1:0]         medial_index,
  output logic [hgag_pkg::IDX_W-1:0]         final_index,
  output logic [hgag_pkg::INIT_ADDR_W-1:0]   initial_glyph_addr,
  output logic [hgag_pkg::MED_ADDR_W-1:0]    medial_glyph_addr,
  output logic [hgag_pkg::FIN_ADDR_W-1:0]    final_glyph_addr,
  output logic                               not_syllable
);

  logic                          in_valid;
  logic [hgag_pkg::BYTE_W-1:0]   lead_q;
  logic [hgag_pkg::BYTE_W-1:0]   second_q;
  logic [hgag_pkg::BYTE_W-1:0]   third_q;
  hgag_pkg::split_t              split;

  // No request is taken while reset is held.
  assign busy = rst;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    lead_q   <= lead_byte;
    second_q <= second_byte;
    third_q  <= third_byte;
  end

  hgag_split u_split (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .lead_byte   (lead_q),
    .second_byte (second_q),
    .third_byte  (third_q),
    .split       (split)
  );

  hgag_compose #(
    .GLYPH_BYTES (GLYPH_BYTES)
  ) u_compose (
    .clk                (clk),
    .rst                (rst),
    .split              (split),
    .done               (done),
    .initial_index      (initial_index),
    .medial_index       (medial_index),
    .final_index        (final_index),
    .initial_glyph_addr (initial_glyph_addr),
    .medial_glyph_addr  (medial_glyph_addr),
    .final_glyph_addr   (final_glyph_addr),
    .not_syllable       (not_syllable)
  );

  // Every request yields its result, and no result appears without a
  // request.
  `HGAG_ASSERT_NEXT(a_latency, start && !busy, ##2 done, "result missing after request")
  `HGAG_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 3), "result without request")
  `HGAG_ASSERT_IMP(a_zero_on_reject, done && not_syllable, (initial_index == '0) && (medial_index == '0) && (final_index == '0) && (initial_glyph_addr == '0) && (medial_glyph_addr == '0) && (final_glyph_addr == '0), "nonzero field on rejected code point")
  `HGAG_ASSERT_IMP(a_index_range, done && !not_syllable, (initial_index <= 5'd18) && (medial_index <= 5'd20) && (final_index <= 5'd27), "jamo index out of range")

endmodule
